// ===== rtl/core/teadec_pkg.sv =====
`timescale 1ns / 1ps

package teadec_pkg;

    // Key schedule step of the cipher.
    localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

    // Shift amounts of the mixing function.
    localparam int unsigned MIX_SHL = 4;
    localparam int unsigned MIX_SHR = 5;

    // One 64-bit block as it moves down the pipeline.
    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
    } teadec_block_t;

    // Round mixing term; every add wraps at 32 bits.
    function automatic logic [31:0] mix_term(
        input logic [31:0] x,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        logic [31:0] t_shl;
        logic [31:0] t_sum;
        logic [31:0] t_shr;
        t_shl = (x << MIX_SHL) + ka;
        t_sum = x + sum;
        t_shr = (x >> MIX_SHR) + kb;
        return t_shl ^ t_sum ^ t_shr;
    endfunction

endpackage

// ===== rtl/core/teadec_stage.sv =====
`timescale 1ns / 1ps

module teadec_stage #(
    parameter logic [31:0] SUM         = 32'h0,
    parameter bit          UPDATE_HIGH = 1'b1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [31:0]               key_a,
    input  logic [31:0]               key_b,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  teadec_pkg::teadec_block_t up_data,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output teadec_pkg::teadec_block_t dn_data
);
    import teadec_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    teadec_block_t data_reg;
    teadec_block_t data_next;

    // The stage takes a transfer when it is empty or its content moves on.
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_valid;

    // Half round: one half of the block is reduced by the mix of the other.
    always_comb
    begin
        data_next = up_data;
        if (UPDATE_HIGH)
        begin
            data_next.hi = up_data.hi - mix_term(up_data.lo, SUM, key_a, key_b);
        end
        else
        begin
            data_next.lo = up_data.lo - mix_term(up_data.hi, SUM, key_a, key_b);
        end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Block data of the stage.
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== rtl/core/tea_block_decrypt.sv =====
`timescale 1ns / 1ps

// TEA block decryption, fully pipelined.
//
// Input channel: cipher_low/cipher_high with cipher_valid/cipher_ready.
// Output channel: plain_low/plain_high with plain_valid/plain_ready.
// A transfer happens at a rising edge where valid and ready are both high.
// The 128-bit key sits in four 32-bit APB registers at bytes 0, 4, 8 and 12;
// keys must be changed only while the pipeline is empty; nothing enforces it.
//
// Each round is split into two half-round stages, one per block half, so the
// pipeline has 2*ROUND_COUNT register stages. Throughput is one block per cycle
// while the receiver does not stall; each stage holds one adder chain of the
// mixing function and one subtract.
// Reset clears every stage valid bit and loads the key registers with 128,
// 129, 130 and 131. When the receiver stalls, blocks keep moving up into empty
// stages behind the output; cipher_ready drops only once the whole pipeline
// is full, and nothing is dropped or repeated.
module tea_block_decrypt #(
    parameter int unsigned ROUND_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Ciphertext input
    input  logic        cipher_valid,
    output logic        cipher_ready,
    input  logic [31:0] cipher_low,
    input  logic [31:0] cipher_high,
    // Plaintext output
    output logic        plain_valid,
    input  logic        plain_ready,
    output logic [31:0] plain_low,
    output logic [31:0] plain_high
);
    import teadec_pkg::*;

    localparam int unsigned STAGES = 2 * ROUND_COUNT;

    // Register indexes on the configuration port.
    localparam logic [1:0] KEY0_IDX = 2'd0;
    localparam logic [1:0] KEY1_IDX = 2'd1;
    localparam logic [1:0] KEY2_IDX = 2'd2;
    localparam logic [1:0] KEY3_IDX = 2'd3;

    logic [31:0] key0_reg;
    logic [31:0] key1_reg;
    logic [31:0] key2_reg;
    logic [31:0] key3_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    logic          stage_valid [0:STAGES];
    logic          stage_ready [0:STAGES];
    teadec_block_t stage_data  [0:STAGES];

    // Configuration writes complete in the APB access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= 32'd128;
            key1_reg <= 32'd129;
            key2_reg <= 32'd130;
            key3_reg <= 32'd131;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                KEY0_IDX: key0_reg <= pwdata;
                KEY1_IDX: key1_reg <= pwdata;
                KEY2_IDX: key2_reg <= pwdata;
                KEY3_IDX: key3_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (cfg_index)
            KEY0_IDX: prdata = key0_reg;
            KEY1_IDX: prdata = key1_reg;
            KEY2_IDX: prdata = key2_reg;
            KEY3_IDX: prdata = key3_reg;
            default:  prdata = key0_reg;
        endcase
    end

    // Pipeline entry and exit.
    assign stage_valid[0]   = cipher_valid;
    assign stage_data[0].lo = cipher_low;
    assign stage_data[0].hi = cipher_high;
    assign cipher_ready     = stage_ready[0];

    assign plain_valid         = stage_valid[STAGES];
    assign stage_ready[STAGES] = plain_ready;
    assign plain_low           = stage_data[STAGES].lo;
    assign plain_high          = stage_data[STAGES].hi;

    // Half-round stages; the round sum is a constant of each stage.
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam int unsigned ROUND     = s / 2;
        localparam bit          HIGH_SIDE = ((s % 2) == 0);
        localparam logic [63:0] SUM_WIDE  =
            64'(TEA_DELTA) * 64'(ROUND_COUNT - ROUND);

        teadec_stage #(
            .SUM         (SUM_WIDE[31:0]),
            .UPDATE_HIGH (HIGH_SIDE)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .key_a    (HIGH_SIDE ? key2_reg : key0_reg),
            .key_b    (HIGH_SIDE ? key3_reg : key1_reg),
            .up_valid (stage_valid[s]),
            .up_ready (stage_ready[s]),
            .up_data  (stage_data[s]),
            .dn_valid (stage_valid[s + 1]),
            .dn_ready (stage_ready[s + 1]),
            .dn_data  (stage_data[s + 1])
        );
    end

`ifndef SYNTHESIS
    // The input side stalls only behind a stalled, occupied output.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !cipher_ready |-> (plain_valid && !plain_ready))
        else $error("input stalled without an output stall");

    // A free output never blocks the input side.
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        plain_ready |-> cipher_ready)
        else $error("input not ready while output ready");

    // With nothing coming into the last stage, the output empties once drained.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!stage_valid[STAGES - 1] && (plain_ready || !plain_valid)) |=> !plain_valid)
        else $error("result appeared with no block behind it");
`endif

endmodule
